// ===== design/stl_pkg.sv =====
// Shared types and constants for the span timer.
// No dependencies; imported by stl_dp, stl_ctrl and span_timer_with_loop_modes.
package stl_pkg;

   localparam int STL_FRAC_BITS  = 16;
   localparam int STL_TIME_WIDTH = 32;
   localparam int SPEED_WIDTH    = 16;
   localparam int CYC_WIDTH      = 16;
   localparam int EVT_WIDTH      = 16;
   localparam int CNT_WIDTH      = 8;

   typedef logic [2:0] mode_type;
   localparam mode_type MODE_NORMAL       = 3'd0;
   localparam mode_type MODE_REVERSE      = 3'd1;
   localparam mode_type MODE_CONTINUE     = 3'd2;
   localparam mode_type MODE_CONTINUE_REV = 3'd3;
   localparam mode_type MODE_LOOP         = 3'd4;
   localparam mode_type MODE_LOOP_REV     = 3'd5;
   localparam mode_type MODE_PING_PONG    = 3'd6;
   localparam mode_type MODE_ALT_NORMAL   = 3'd7;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_TICK     = 2'd0;
   localparam cmd_type CMD_START    = 2'd1;
   localparam cmd_type CMD_SET_TIME = 2'd2;

   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_MODE       = 2'd0;
   localparam csr_idx_type CSR_SPAN_START = 2'd1;
   localparam csr_idx_type CSR_SPAN_END   = 2'd2;
   localparam csr_idx_type CSR_SPEED      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_EVAL,
      ST_DIV,
      ST_APPLY,
      ST_FMUL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic add;
      logic div_start;
      logic apply;
      logic fmul;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } dp_status_type;

endpackage

// ===== design/stl_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters; used by stl_dp.
module stl_div #(
   parameter int DW = 42,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = shifted >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(DW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], fits};
         rem_ff <= fits ? diff[VW-1:0] : shifted[VW-1:0];
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/stl_dp.sv =====
// Datapath: config registers, timer state, tick arithmetic and result registers.
// Depends on stl_pkg and stl_div; driven by commands from stl_ctrl.
module stl_dp
   import stl_pkg::*;
#(
   parameter int FRAC_BITS  = STL_FRAC_BITS,
   parameter int TIME_WIDTH = STL_TIME_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ctrl_cmd_type                        ctrl,
   output dp_status_type                       status,
   input  cmd_type                             req_command,
   input  logic signed [TIME_WIDTH-1:0]        req_amount,
   input  logic                                csr_write_enable,
   input  csr_idx_type                         csr_index,
   input  logic [TIME_WIDTH-1:0]               csr_write_data,
   output logic signed [TIME_WIDTH-1:0]        rsp_time_value,
   output logic signed [CYC_WIDTH-1:0]         rsp_cycle_count,
   output logic [EVT_WIDTH-1:0]                rsp_spans_done,
   output logic [CNT_WIDTH-1:0]                rsp_ends_this_item,
   output logic [CNT_WIDTH-1:0]                rsp_loops_this_item,
   output logic                                rsp_began_span,
   output logic                                rsp_running,
   output logic                                rsp_moving_down
);

   localparam int TW = TIME_WIDTH;
   localparam int PW = TW + SPEED_WIDTH;
   localparam int XW = TW + 10;
   localparam int DW = XW;
   localparam int EW = DW + 1;
   localparam int LW = TW + 1;
   localparam int FW = TW + 19;
   localparam logic signed [FW-1:0] TMAX_F = (FW'(1) <<< (TW - 1)) - FW'(1);
   localparam logic signed [FW-1:0] TMIN_F = -TMAX_F - FW'(1);

   function automatic logic signed [TW-1:0] sat_time(input logic signed [FW-1:0] x);
      logic signed [TW-1:0] y;
      if (x > TMAX_F) begin
         y = TMAX_F[TW-1:0];
      end else if (x < TMIN_F) begin
         y = TMIN_F[TW-1:0];
      end else begin
         y = x[TW-1:0];
      end
      return y;
   endfunction

   function automatic logic signed [CYC_WIDTH-1:0] add_cyc(
      input logic signed [CYC_WIDTH-1:0] c, input logic [EW-1:0] n, input logic neg);
      logic [16:0]        nc;
      logic signed [17:0] s;
      logic signed [CYC_WIDTH-1:0] y;
      nc = (n > EW'(65536)) ? 17'h10000 : n[16:0];
      s  = neg ? (18'(c) - $signed({1'b0, nc})) : (18'(c) + $signed({1'b0, nc}));
      if (s > 18'sd32767) begin
         y = 16'sh7fff;
      end else if (s < -18'sd32768) begin
         y = 16'sh8000;
      end else begin
         y = s[15:0];
      end
      return y;
   endfunction

   // config
   mode_type                     mode_ff;
   logic signed [TW-1:0]         start_ff;
   logic signed [TW-1:0]         end_ff;
   logic signed [SPEED_WIDTH-1:0] speed_ff;

   // item and working registers
   cmd_type                      cmd_ff;
   logic signed [TW-1:0]         amount_ff;
   logic signed [PW-1:0]         prod_ff;
   logic signed [XW-1:0]         t_ff;
   logic signed [LW+CYC_WIDTH-1:0] fprod_ff;

   // timer state
   logic signed [TW-1:0]         cur_ff;
   logic signed [CYC_WIDTH-1:0]  cyc_ff;
   logic                         down_ff;
   logic [EVT_WIDTH-1:0]         events_ff;
   logic                         run_ff;
   logic [CNT_WIDTH-1:0]         ends_ff;
   logic [CNT_WIDTH-1:0]         loops_ff;
   logic                         began_ff;

   // result registers
   logic signed [TW-1:0]         time_out_ff;
   logic signed [CYC_WIDTH-1:0]  cyc_out_ff;
   logic [EVT_WIDTH-1:0]         events_out_ff;
   logic [CNT_WIDTH-1:0]         ends_out_ff;
   logic [CNT_WIDTH-1:0]         loops_out_ff;
   logic                         began_out_ff;
   logic                         run_out_ff;
   logic                         down_out_ff;

   mode_type                     eff_mode;
   logic signed [LW-1:0]         len;
   logic                         len_neg;
   logic                         len_zero;
   logic [TW-1:0]                lenabs;
   logic signed [XW-1:0]         start_x;
   logic signed [XW-1:0]         end_x;
   logic signed [XW-1:0]         len_x;
   logic signed [XW-1:0]         lenabs_x;
   logic signed [XW-1:0]         amt_x;
   logic signed [PW:0]           pn;
   logic signed [XW-1:0]         t_in;
   logic                         t_ge_end;
   logic                         t_lt_start;
   logic                         t_le_start;
   logic                         tick_live;
   logic signed [XW-1:0]         d_set;
   logic signed [XW-1:0]         d_te;
   logic signed [XW-1:0]         d_st;
   logic signed [XW-1:0]         d_ts;
   logic [DW-1:0]                dividend;
   logic                         need_div;
   logic                         div_busy;
   logic [DW-1:0]                quo;
   logic [TW-1:0]                rem;
   logic signed [XW-1:0]         r_x;
   logic                         rnz;
   logic [EW-1:0]                qp1;

   logic signed [XW-1:0]         t_new;
   logic signed [CYC_WIDTH-1:0]  cyc_in;
   logic                         run_in;
   logic                         down_in;
   logic [EW-1:0]                ends_new;
   logic                         loop_ev;
   logic                         began_in;
   logic                         clear_events;
   logic [EW-1:0]                k;
   logic [TW-1:0]                uf;
   logic [EW-1:0]                qmag;
   logic                         qneg;
   logic [EVT_WIDTH-1:0]         evt_base;
   logic [EVT_WIDTH-1:0]         ends16;
   logic [EVT_WIDTH:0]           evt_sum;
   logic signed [TW-1:0]         ft;

   assign eff_mode = (mode_ff == MODE_ALT_NORMAL) ? MODE_NORMAL : mode_ff;
   assign len      = LW'(end_ff) - LW'(start_ff);
   assign len_neg  = len[LW-1];
   assign len_zero = (len == '0);
   assign lenabs   = len_neg ? TW'(-len) : len[TW-1:0];
   assign start_x  = XW'(start_ff);
   assign end_x    = XW'(end_ff);
   assign len_x    = XW'(len);
   assign lenabs_x = $signed(XW'(lenabs));
   assign amt_x    = XW'(amount_ff);

   assign pn   = down_ff ? -$signed({prod_ff[PW-1], prod_ff}) : $signed({prod_ff[PW-1], prod_ff});
   assign t_in = XW'(cur_ff) + XW'($signed(pn[PW:8]));

   assign t_ge_end   = t_ff >= end_x;
   assign t_lt_start = t_ff < start_x;
   assign t_le_start = t_ff <= start_x;
   assign tick_live  = run_ff && (amount_ff != '0) && !len_zero && !len_neg;

   assign d_set = amt_x - start_x;
   assign d_te  = t_ff - end_x;
   assign d_st  = start_x - t_ff;
   assign d_ts  = t_ff - start_x;

   always_comb begin
      need_div = 1'b0;
      dividend = DW'(d_te);
      unique case (cmd_ff)
         CMD_TICK: begin
            if (tick_live) begin
               unique case (eff_mode)
                  MODE_CONTINUE, MODE_LOOP: begin
                     need_div = t_ge_end;
                     dividend = DW'(d_te);
                  end
                  MODE_CONTINUE_REV, MODE_LOOP_REV: begin
                     need_div = t_le_start;
                     dividend = DW'(d_st);
                  end
                  MODE_PING_PONG: begin
                     need_div = t_lt_start || t_ge_end;
                     dividend = t_ge_end ? DW'(d_ts) : DW'(d_st);
                  end
                  default: begin
                     need_div = 1'b0;
                  end
               endcase
            end
         end
         CMD_SET_TIME: begin
            need_div = (eff_mode != MODE_NORMAL) && (eff_mode != MODE_REVERSE) && !len_zero;
            dividend = d_set[XW-1] ? DW'(-d_set) : DW'(d_set);
         end
         default: begin
            need_div = 1'b0;
         end
      endcase
   end

   stl_div #(
      .DW(DW),
      .VW(TW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  (dividend),
      .divisor   (lenabs),
      .busy      (div_busy),
      .quotient  (quo),
      .remainder (rem)
   );

   assign status.need_div = need_div;
   assign status.div_done = !div_busy;

   assign r_x = $signed(XW'(rem));
   assign rnz = (rem != '0);
   assign qp1 = EW'(quo) + EW'(1);

   always_comb begin
      t_new        = XW'(cur_ff);
      cyc_in       = cyc_ff;
      run_in       = run_ff;
      down_in      = down_ff;
      ends_new     = '0;
      loop_ev      = 1'b0;
      began_in     = 1'b0;
      clear_events = 1'b0;
      k            = '0;
      uf           = '0;
      qmag         = '0;
      qneg         = 1'b0;
      unique case (cmd_ff)
         CMD_TICK: begin
            if (run_ff && (amount_ff != '0)) begin
               if (len_zero) begin
                  run_in = 1'b0;
               end else begin
                  t_new = t_ff;
                  unique case (eff_mode)
                     MODE_REVERSE: begin
                        if (t_lt_start) begin
                           ends_new = EW'(1);
                           t_new    = start_x;
                           cyc_in   = -16'sd1;
                           run_in   = 1'b0;
                        end
                     end
                     MODE_CONTINUE, MODE_LOOP: begin
                        if (t_ge_end) begin
                           if (len_neg) begin
                              ends_new = EW'(1);
                              t_new    = end_x;
                              run_in   = 1'b0;
                           end else begin
                              ends_new = qp1;
                              loop_ev  = 1'b1;
                              began_in = 1'b1;
                              t_new    = end_x + r_x - len_x;
                              if (eff_mode == MODE_CONTINUE) begin
                                 cyc_in = add_cyc(cyc_ff, qp1, 1'b0);
                              end
                           end
                        end
                     end
                     MODE_CONTINUE_REV, MODE_LOOP_REV: begin
                        if (t_le_start) begin
                           if (len_neg) begin
                              ends_new = EW'(1);
                              t_new    = start_x;
                              run_in   = 1'b0;
                           end else begin
                              ends_new = qp1;
                              loop_ev  = 1'b1;
                              began_in = 1'b1;
                              t_new    = start_x - r_x + len_x;
                              if (eff_mode == MODE_CONTINUE_REV) begin
                                 cyc_in = add_cyc(cyc_ff, qp1, 1'b1);
                              end
                           end
                        end
                     end
                     MODE_PING_PONG: begin
                        if (len_neg) begin
                           ends_new = EW'(1);
                           t_new    = down_ff ? start_x : end_x;
                           run_in   = 1'b0;
                        end else if (t_lt_start || t_ge_end) begin
                           if (t_ge_end) begin
                              if (rnz) begin
                                 k  = EW'(quo);
                                 uf = quo[0] ? (lenabs - rem) : rem;
                              end else if (quo == DW'(1)) begin
                                 k  = EW'(1);
                                 uf = lenabs;
                              end else begin
                                 k  = EW'(quo) - EW'(1);
                                 uf = quo[0] ? lenabs : '0;
                              end
                           end else begin
                              if (rnz) begin
                                 k  = qp1;
                                 uf = quo[0] ? (lenabs - rem) : rem;
                              end else begin
                                 k  = EW'(quo);
                                 uf = quo[0] ? lenabs : '0;
                              end
                           end
                           t_new    = start_x + $signed(XW'(uf));
                           down_in  = k[0] ? !down_ff : down_ff;
                           ends_new = k;
                           loop_ev  = 1'b1;
                           began_in = 1'b1;
                        end
                     end
                     default: begin
                        if (t_ge_end) begin
                           ends_new = EW'(1);
                           t_new    = end_x;
                           cyc_in   = 16'sd1;
                           run_in   = 1'b0;
                        end
                     end
                  endcase
               end
            end
         end
         CMD_START: begin
            run_in       = 1'b1;
            t_new        = down_ff ? end_x : start_x;
            cyc_in       = '0;
            clear_events = 1'b1;
            began_in     = 1'b1;
         end
         CMD_SET_TIME: begin
            if ((eff_mode == MODE_NORMAL) || (eff_mode == MODE_REVERSE)) begin
               if (amt_x < start_x) begin
                  t_new = start_x;
               end else if (amt_x > end_x) begin
                  t_new = end_x;
               end else begin
                  t_new = amt_x;
               end
            end else begin
               if (len_zero) begin
                  t_new = start_x;
               end else if (!d_set[XW-1]) begin
                  t_new = start_x + r_x;
                  qmag  = EW'(quo);
               end else if (rnz) begin
                  t_new = start_x + lenabs_x - r_x;
                  qmag  = qp1;
                  qneg  = 1'b1;
               end else begin
                  t_new = start_x;
                  qmag  = EW'(quo);
                  qneg  = 1'b1;
               end
               if ((eff_mode == MODE_CONTINUE) || (eff_mode == MODE_CONTINUE_REV)) begin
                  if (qneg) begin
                     cyc_in = (qmag > EW'(32768)) ? 16'sh8000 : -$signed(qmag[15:0]);
                  end else begin
                     cyc_in = (qmag > EW'(32767)) ? 16'sh7fff : $signed(qmag[15:0]);
                  end
               end else begin
                  cyc_in = '0;
                  if (eff_mode == MODE_PING_PONG) begin
                     down_in = qmag[0];
                  end
               end
            end
         end
         default: begin
            t_new = XW'(cur_ff);
         end
      endcase
   end

   assign evt_base = clear_events ? '0 : events_ff;
   assign ends16   = (ends_new > EW'(65535)) ? 16'hffff : ends_new[15:0];
   assign evt_sum  = {1'b0, evt_base} + {1'b0, ends16};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         start_ff  <= '0;
         end_ff    <= TW'(1) << FRAC_BITS;
         speed_ff  <= 16'sd256;
         cur_ff    <= '0;
         cyc_ff    <= '0;
         down_ff   <= 1'b0;
         events_ff <= '0;
         run_ff    <= 1'b0;
      end else if (ctrl.apply) begin
         cur_ff    <= sat_time(FW'(t_new));
         cyc_ff    <= cyc_in;
         run_ff    <= run_in;
         down_ff   <= down_in;
         events_ff <= evt_sum[EVT_WIDTH] ? '1 : evt_sum[EVT_WIDTH-1:0];
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_ff <= csr_write_data[2:0];
               down_ff <= (csr_write_data[2:0] == MODE_REVERSE)
                       || (csr_write_data[2:0] == MODE_CONTINUE_REV)
                       || (csr_write_data[2:0] == MODE_LOOP_REV);
            end
            CSR_SPAN_START: start_ff <= csr_write_data;
            CSR_SPAN_END:   end_ff   <= csr_write_data;
            default:        speed_ff <= csr_write_data[SPEED_WIDTH-1:0];
         endcase
      end
   end

   assign ft = ((eff_mode == MODE_CONTINUE) || (eff_mode == MODE_CONTINUE_REV))
             ? sat_time(FW'(cur_ff) + FW'(fprod_ff)) : cur_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff    <= req_command;
         amount_ff <= req_amount;
      end
      if (ctrl.mul) begin
         prod_ff <= amount_ff * speed_ff;
      end
      if (ctrl.add) begin
         t_ff <= t_in;
      end
      if (ctrl.apply) begin
         ends_ff  <= (ends_new > EW'(255)) ? 8'hff : ends_new[7:0];
         loops_ff <= (loop_ev && (ends_new > EW'(255))) ? 8'hff
                   : (loop_ev ? ends_new[7:0] : 8'h00);
         began_ff <= began_in;
      end
      if (ctrl.fmul) begin
         fprod_ff <= len * cyc_ff;
      end
      if (ctrl.load_rsp) begin
         time_out_ff   <= ft;
         cyc_out_ff    <= cyc_ff;
         events_out_ff <= events_ff;
         ends_out_ff   <= ends_ff;
         loops_out_ff  <= loops_ff;
         began_out_ff  <= began_ff;
         run_out_ff    <= run_ff;
         down_out_ff   <= down_ff;
      end
   end

   assign rsp_time_value      = time_out_ff;
   assign rsp_cycle_count     = cyc_out_ff;
   assign rsp_spans_done      = events_out_ff;
   assign rsp_ends_this_item  = ends_out_ff;
   assign rsp_loops_this_item = loops_out_ff;
   assign rsp_began_span      = began_out_ff;
   assign rsp_running         = run_out_ff;
   assign rsp_moving_down     = down_out_ff;

endmodule

// ===== design/stl_ctrl.sv =====
// Controller state machine: sequences one item through the datapath.
// Depends on stl_pkg; talks to stl_dp through command and status structs.
module stl_ctrl
   import stl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  ctrl
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_busy;

   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_EVAL;
         ST_EVAL:  state_in = status.need_div ? ST_DIV : ST_APPLY;
         ST_DIV:   if (status.div_done) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_FMUL;
         ST_FMUL:  state_in = ST_RESP;
         ST_RESP:  if (!rsp_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      req_ready      = (state_ff == ST_IDLE);
      ctrl.capture   = (state_ff == ST_IDLE) && req_valid;
      ctrl.mul       = (state_ff == ST_MUL);
      ctrl.add       = (state_ff == ST_ADD);
      ctrl.div_start = (state_ff == ST_EVAL) && status.need_div;
      ctrl.apply     = (state_ff == ST_APPLY);
      ctrl.fmul      = (state_ff == ST_FMUL);
      ctrl.load_rsp  = (state_ff == ST_RESP) && !rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctrl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/span_timer_with_loop_modes.sv =====
// Span timer with normal, reverse, loop, continue and ping-pong modes, signed
// fixed point time. One item is in flight at a time; an item passes through the
// multiply, add, evaluate, apply, final-multiply and response states, and through
// the one-bit-per-cycle divider when a wrap, reflection or set_time needs it.
// The result sits in an output register, so the next request transfers while it waits.
module span_timer_with_loop_modes
   import stl_pkg::*;
#(
   parameter int FRAC_BITS  = STL_FRAC_BITS,
   parameter int TIME_WIDTH = STL_TIME_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic signed [TIME_WIDTH-1:0]  req_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [TIME_WIDTH-1:0]  rsp_time_value,
   output logic signed [CYC_WIDTH-1:0]   rsp_cycle_count,
   output logic [EVT_WIDTH-1:0]          rsp_spans_done,
   output logic [CNT_WIDTH-1:0]          rsp_ends_this_item,
   output logic [CNT_WIDTH-1:0]          rsp_loops_this_item,
   output logic                          rsp_began_span,
   output logic                          rsp_running,
   output logic                          rsp_moving_down,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [TIME_WIDTH-1:0]         csr_write_data
);

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   stl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   stl_dp #(
      .FRAC_BITS  (FRAC_BITS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .status              (status),
      .req_command         (req_command),
      .req_amount          (req_amount),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_time_value      (rsp_time_value),
      .rsp_cycle_count     (rsp_cycle_count),
      .rsp_spans_done      (rsp_spans_done),
      .rsp_ends_this_item  (rsp_ends_this_item),
      .rsp_loops_this_item (rsp_loops_this_item),
      .rsp_began_span      (rsp_began_span),
      .rsp_running         (rsp_running),
      .rsp_moving_down     (rsp_moving_down)
   );

endmodule

// ===== sim/span_timer_with_loop_modes_test.sv =====
// Self-checking testbench for span_timer_with_loop_modes: random and directed commands
// over many mode/span/speed settings, checked against an in-bench timer predictor.
// Depends on design/stl_pkg.sv and design/span_timer_with_loop_modes.sv.
`timescale 1ns / 1ps
module span_timer_with_loop_modes_test;
   import stl_pkg::*;

   localparam longint TIME_MAX = 64'sd2147483647;
   localparam longint TIME_MIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 60;
   localparam cmd_type CMD_RESERVED = 2'd3;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] amount;
   } timer_cmd_type;

   typedef struct packed {
      logic signed [31:0] time_value;
      logic signed [15:0] cycle_count;
      logic [15:0]        spans_done;
      logic [7:0]         ends_this_item;
      logic [7:0]         loops_this_item;
      logic               began_span;
      logic               running;
      logic               moving_down;
   } timer_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_command = CMD_TICK;
   logic signed [31:0] req_amount = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_time_value;
   logic signed [15:0] rsp_cycle_count;
   logic [15:0] rsp_spans_done;
   logic [7:0] rsp_ends_this_item, rsp_loops_this_item;
   logic rsp_began_span, rsp_running, rsp_moving_down;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = CSR_MODE;
   logic [31:0] csr_write_data = 0;

   span_timer_with_loop_modes u_top (.*);

   initial forever #10 clock = ~clock;

   timer_cmd_type pending_cmds[$];
   timer_rsp_type expected_rsps[$];
   int sender_idle_pct = 0;
   int sink_stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;

   // configuration and state mirror
   mode_type cfg_mode = MODE_NORMAL;
   longint cfg_start = 0, cfg_end = 65536, cfg_speed = 256;
   longint now_time = 0;
   int cycles = 0;
   bit going_down = 0;
   int unsigned span_count = 0;
   bit is_running = 0;

   function automatic longint clamp_time(longint x);
      if (x > TIME_MAX) return TIME_MAX;
      if (x < TIME_MIN) return TIME_MIN;
      return x;
   endfunction

   function automatic int clamp16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return int'(x);
   endfunction

   function automatic longint div_floor(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic void bump_cycles(longint d);
      if (d > 65536) d = 65536;
      if (d < -65536) d = -65536;
      cycles = clamp16(cycles + d);
   endfunction

   function automatic mode_type active_mode();
      return (cfg_mode == MODE_ALT_NORMAL) ? MODE_NORMAL : cfg_mode;
   endfunction

   function automatic longint shown_time();
      mode_type m;
      longint len, al, ac;
      m = active_mode();
      if ((m != MODE_CONTINUE && m != MODE_CONTINUE_REV) || cycles == 0) return now_time;
      len = cfg_end - cfg_start;
      al = len < 0 ? -len : len;
      ac = cycles < 0 ? -cycles : cycles;
      if (al > (64'sd1 <<< 32) / ac)
         return ((len < 0) != (cycles < 0)) ? TIME_MIN : TIME_MAX;
      return clamp_time(now_time + len * cycles);
   endfunction

   function automatic void advance_tick(longint step, ref longint ends, ref longint loops,
                                        ref bit began);
      mode_type m;
      longint len, p, t, n, u, v, k, uf;
      m = active_mode();
      if (!is_running || step == 0) return;
      len = cfg_end - cfg_start;
      if (len == 0) begin
         is_running = 0;
         return;
      end
      p = step * cfg_speed;
      if (going_down) p = -p;
      t = now_time + div_floor(p, 256);
      case (m)
         MODE_NORMAL: begin
            if (t >= cfg_end) begin
               ends = 1; t = cfg_end; cycles = 1; is_running = 0;
            end
         end
         MODE_REVERSE: begin
            if (t < cfg_start) begin
               ends = 1; t = cfg_start; cycles = -1; is_running = 0;
            end
         end
         MODE_CONTINUE, MODE_LOOP: begin
            if (t >= cfg_end) begin
               if (len < 0) begin
                  ends = 1; t = cfg_end; is_running = 0;
               end else begin
                  n = div_floor(t - cfg_end, len) + 1;
                  t -= n * len;
                  ends = n; loops = n; began = 1;
                  if (m == MODE_CONTINUE) bump_cycles(n);
               end
            end
         end
         MODE_CONTINUE_REV, MODE_LOOP_REV: begin
            if (t <= cfg_start) begin
               if (len < 0) begin
                  ends = 1; t = cfg_start; is_running = 0;
               end else begin
                  n = div_floor(cfg_start - t, len) + 1;
                  t += n * len;
                  ends = n; loops = n; began = 1;
                  if (m == MODE_CONTINUE_REV) bump_cycles(-n);
               end
            end
         end
         default: begin
            if (len < 0) begin
               ends = 1; t = going_down ? cfg_start : cfg_end; is_running = 0;
            end else if (t < cfg_start || t >= cfg_end) begin
               u = t - cfg_start;
               if (u >= len) begin
                  k = (u == len) ? 1 : (u + len - 1) / len - 1;
                  uf = k[0] ? (k + 1) * len - u : u - k * len;
               end else begin
                  v = -u;
                  k = (v + len - 1) / len;
                  uf = k[0] ? v - (k - 1) * len : k * len - v;
               end
               t = cfg_start + uf;
               if (k[0]) going_down = !going_down;
               ends = k; loops = k; began = 1;
            end
         end
      endcase
      now_time = clamp_time(t);
   endfunction

   function automatic void place_time(longint tv);
      mode_type m;
      longint len, q, t;
      m = active_mode();
      q = 0;
      if (m == MODE_NORMAL || m == MODE_REVERSE) begin
         t = tv;
         if (t < cfg_start) t = cfg_start;
         else if (t > cfg_end) t = cfg_end;
         now_time = t;
         return;
      end
      len = cfg_end - cfg_start;
      if (len < 0) len = -len;
      if (len == 0) t = cfg_start;
      else begin
         q = div_floor(tv - cfg_start, len);
         t = cfg_start + (tv - cfg_start - q * len);
      end
      now_time = clamp_time(t);
      if (m == MODE_CONTINUE || m == MODE_CONTINUE_REV) cycles = clamp16(q);
      else begin
         cycles = 0;
         if (m == MODE_PING_PONG) going_down = q[0];
      end
   endfunction

   function automatic timer_rsp_type predict_timer(timer_cmd_type c);
      timer_rsp_type r;
      longint ends, loops, amt, sum;
      bit began;
      ends = 0; loops = 0; began = 0;
      amt = longint'($signed(c.amount));
      if (c.cmd == CMD_TICK) advance_tick(amt, ends, loops, began);
      else if (c.cmd == CMD_START) begin
         is_running = 1;
         now_time = going_down ? cfg_end : cfg_start;
         cycles = 0;
         span_count = 0;
         began = 1;
      end else if (c.cmd == CMD_SET_TIME) place_time(amt);
      sum = longint'(span_count) + (ends > 65535 ? 65535 : ends);
      span_count = (sum > 65535) ? 65535 : int'(sum);
      r.time_value = 32'(shown_time());
      r.cycle_count = 16'(cycles);
      r.spans_done = 16'(span_count);
      r.ends_this_item = 8'(ends > 255 ? 255 : ends);
      r.loops_this_item = 8'(loops > 255 ? 255 : loops);
      r.began_span = began;
      r.running = is_running;
      r.moving_down = going_down;
      return r;
   endfunction

   // mirror the registers at the edge the block takes them
   always @(posedge clock) begin
      if (!reset && csr_write_enable) begin
         case (csr_index)
            CSR_MODE: begin
               cfg_mode = csr_write_data[2:0];
               going_down = (cfg_mode == MODE_REVERSE || cfg_mode == MODE_CONTINUE_REV ||
                             cfg_mode == MODE_LOOP_REV);
            end
            CSR_SPAN_START: cfg_start = longint'($signed(csr_write_data));
            CSR_SPAN_END:   cfg_end = longint'($signed(csr_write_data));
            CSR_SPEED:      cfg_speed = longint'($signed(csr_write_data[15:0]));
         endcase
      end
   end

   // driver
   always @(posedge clock) begin
      timer_cmd_type c;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            c = pending_cmds.pop_front();
            req_valid <= 1;
            req_command <= c.cmd;
            req_amount <= c.amount;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // predictor on each input transfer
   always @(posedge clock) begin
      timer_cmd_type c;
      if (!reset && req_valid && req_ready) begin
         c.cmd = req_command;
         c.amount = req_amount;
         expected_rsps.push_back(predict_timer(c));
      end
   end

   // monitor
   always @(posedge clock) begin
      timer_rsp_type got, want;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_time_value, rsp_cycle_count, rsp_spans_done, rsp_ends_this_item,
                    rsp_loops_this_item, rsp_began_span, rsp_running, rsp_moving_down};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected transfer %p", $time, got);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_csr(csr_idx_type idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_cmds.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_cmd(cmd_type c, logic [31:0] a);
      timer_cmd_type t;
      t.cmd = c;
      t.amount = a;
      pending_cmds.push_back(t);
   endtask

   task automatic push_random_cmd();
      int pick;
      logic [31:0] a;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: a = $urandom_range(0, 'h30000);
         5: a = $urandom_range(0, 'h4000);
         6: a = $urandom;
         7: a = 0;
         default: a = 32'(-$signed({1'b0, $urandom_range(0, 'h30000)}));
      endcase
      if (pick < 68) push_cmd(CMD_TICK, a);
      else if (pick < 80) push_cmd(CMD_START, $urandom);
      else if (pick < 95) begin
         if ($urandom_range(0, 1))
            a = 32'(cfg_start + $signed($urandom_range(0, 'h80000)) - 'h20000);
         else a = $urandom;
         push_cmd(CMD_SET_TIME, a);
      end else push_cmd(CMD_RESERVED, $urandom);
   endtask

   initial begin
      int ph;
      logic [31:0] s, e, sp;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: reset settings, stopped ticks, extremes, every command
      push_cmd(CMD_TICK, 'h10000);
      push_cmd(CMD_SET_TIME, 32'h8000_0000);
      push_cmd(CMD_SET_TIME, 32'h7fff_ffff);
      push_cmd(CMD_SET_TIME, 'h8000);
      push_cmd(CMD_START, 0);
      push_cmd(CMD_TICK, 0);
      push_cmd(CMD_TICK, 'h4000);
      push_cmd(CMD_TICK, 'h10000);
      push_cmd(CMD_TICK, 'h4000);
      push_cmd(CMD_RESERVED, 32'hffff_ffff);
      push_cmd(CMD_START, 0);
      push_cmd(CMD_TICK, 32'h7fff_ffff);
      push_cmd(CMD_START, 0);
      push_cmd(CMD_TICK, 32'h8000_0000);
      push_cmd(CMD_TICK, 32'hffff_ffff);
      drain();

      for (ph = 0; ph < 17; ph++) begin
         s = $signed($urandom_range(0, 'h80000)) - 'h40000;
         e = s + $urandom_range('h4000, 'h30000);
         sp = $urandom_range(64, 1024);
         case (ph)
            3: sp = 16'h8000;
            5: e = s;
            6, 10: e = s - $urandom_range(1, 'h20000);
            11: begin s = 32'h8000_0000; e = 32'h7fff_ffff; end
            12: begin s = 32'h7fff_ffff; e = 32'h8000_0000; end
            13: sp = 16'h7fff;
            14: sp = 0;
            15: begin e = s + 1; sp = 16'hffff; end
            default: ;
         endcase
         write_csr(CSR_SPAN_START, s);
         write_csr(CSR_SPAN_END, e);
         write_csr(CSR_SPEED, sp);
         write_csr(CSR_MODE, ph % 8);
         sender_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 82 : 13) : 0;
         sink_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 82 : 13) : 0;
         push_cmd(CMD_START, 0);
         repeat (26) push_random_cmd();
         // hold off until everything is back, then continue
         drain();
         repeat (27) push_random_cmd();
         drain();
      end

      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/stl_pkg.sv
design/stl_div.sv
design/stl_dp.sv
design/stl_ctrl.sv
design/span_timer_with_loop_modes.sv
sim/span_timer_with_loop_modes_test.sv
